// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define BU2_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked check, active in and out of reset
`define BU2_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/bu2_pkg.sv =====
// ----------------------------------------------------------------------------
// bu2_pkg
// shared types and constants of the 2x bilinear upscaler
// ----------------------------------------------------------------------------
package bu2_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int SIZE_W  = 9;
  localparam int CHAN_W  = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // configuration register indexes
  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // which parity bank holds each of the four neighbors
  typedef struct packed {
    logic       valid;
    logic [1:0] a_bank;
    logic [1:0] b_bank;
    logic [1:0] c_bank;
    logic [1:0] d_bank;
  } rd_sel_t;

endpackage

// ===== rtl/bu2_bank.sv =====
// ----------------------------------------------------------------------------
// bu2_bank
// one parity bank of the frame store, one write and one registered read
// ----------------------------------------------------------------------------
module bu2_bank #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  bu2_pkg::pix_t   wr_data,
  input  logic [AW-1:0]   rd_addr,
  output bu2_pkg::pix_t   rd_data
);

  bu2_pkg::pix_t mem [DEPTH];
  bu2_pkg::pix_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bu2_agen.sv =====
// ----------------------------------------------------------------------------
// bu2_agen
// size clamping, border folding and parity bank addressing
// ----------------------------------------------------------------------------
module bu2_agen #(
  parameter int MAX_WIDTH  = bu2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bu2_pkg::DEF_MAX_HEIGHT,
  parameter int AW         = 14
) (
  input  logic                       accept,
  input  logic                       command,
  input  logic [8:0]                 row,
  input  logic [8:0]                 col,
  input  bu2_pkg::pix_t              pix_in,
  input  logic [8:0]                 width_cfg,
  input  logic [8:0]                 height_cfg,
  output logic                       wr_en,
  output logic [1:0]                 wr_bank,
  output logic [AW-1:0]              wr_addr,
  output bu2_pkg::pix_t              wr_data,
  output logic [3:0][AW-1:0]         rd_addr,
  output bu2_pkg::rd_sel_t           rd_sel
);

  localparam int HALF_W = (MAX_WIDTH + 1) / 2;

  function automatic logic [8:0] clamp_size(input logic [8:0] v, input int maxv);
    if (v < 9'd2) return 9'd2;
    if (32'(v) > maxv) return 9'(maxv);
    return v;
  endfunction

  // bank-local index: half row times half width plus half column
  function automatic logic [AW-1:0] bank_index(input logic [8:0] r, input logic [8:0] c);
    return AW'(32'(r[8:1]) * HALF_W + 32'(c[8:1]));
  endfunction

  logic [8:0] w, h;
  logic [9:0] w2, h2;
  logic [7:0] dr, dc;
  logic [8:0] dr_up, dc_up;
  logic [8:0] nr, nc;
  logic [8:0] rsel0, rsel1, csel0, csel1;

  always_comb begin
    w  = clamp_size(width_cfg, MAX_WIDTH);
    h  = clamp_size(height_cfg, MAX_HEIGHT);
    w2 = {w, 1'b0};
    h2 = {h, 1'b0};
    dr = row[8:1];
    dc = col[8:1];
    dr_up = {1'b0, dr} + 9'd1;
    dc_up = {1'b0, dc} + 9'd1;

    // odd goes down/right, even goes up/left; mirrored at the top/left border, clamped at the bottom/right
    if (row[0]) begin
      nr = (dr_up >= h) ? (h - 9'd1) : dr_up;
    end else begin
      nr = (dr == 8'd0) ? 9'd1 : ({1'b0, dr} - 9'd1);
    end
    if (col[0]) begin
      nc = (dc_up >= w) ? (w - 9'd1) : dc_up;
    end else begin
      nc = (dc == 8'd0) ? 9'd1 : ({1'b0, dc} - 9'd1);
    end

    // each row parity serves one of the two rows, the nearest wins a tie
    rsel0 = (dr[0] == 1'b0) ? {1'b0, dr} : nr;
    rsel1 = (dr[0] == 1'b1) ? {1'b0, dr} : nr;
    csel0 = (dc[0] == 1'b0) ? {1'b0, dc} : nc;
    csel1 = (dc[0] == 1'b1) ? {1'b0, dc} : nc;

    rd_addr[0] = bank_index(rsel0, csel0);
    rd_addr[1] = bank_index(rsel0, csel1);
    rd_addr[2] = bank_index(rsel1, csel0);
    rd_addr[3] = bank_index(rsel1, csel1);

    wr_en   = accept && (command == bu2_pkg::CMD_WRITE) && (row < h) && (col < w);
    wr_bank = {row[0], col[0]};
    wr_addr = bank_index(row, col);
    wr_data = pix_in;

    rd_sel.valid  = accept && (command == bu2_pkg::CMD_READ)
                    && ({1'b0, row} < h2) && ({1'b0, col} < w2);
    rd_sel.a_bank = {nr[0], nc[0]};
    rd_sel.b_bank = {dr[0], nc[0]};
    rd_sel.c_bank = {nr[0], dc[0]};
    rd_sel.d_bank = {dr[0], dc[0]};
  end

endmodule

// ===== rtl/bu2_blend.sv =====
// ----------------------------------------------------------------------------
// bu2_blend
// neighbor selection from the bank outputs and the 1-3-3-9 weighted sum
// ----------------------------------------------------------------------------
module bu2_blend (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bu2_pkg::rd_sel_t        rd_sel,
  input  bu2_pkg::pix_t [3:0]     bank_q,
  output logic                    out_valid,
  output bu2_pkg::pix_t           out_pix
);

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
    logic [11:0] sum;
    sum = 12'(a) + 12'(3) * 12'(b) + 12'(3) * 12'(c) + 12'(9) * 12'(d);
    return sum[11:4];
  endfunction

  logic          valid_r;
  logic [1:0]    a_bank_r, b_bank_r, c_bank_r, d_bank_r;
  logic          out_valid_r;
  bu2_pkg::pix_t out_pix_r, out_pix_nxt;
  bu2_pkg::pix_t pa, pb, pc, pd;

  // selection travels alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rd_sel.valid;
    end
    a_bank_r <= rd_sel.a_bank;
    b_bank_r <= rd_sel.b_bank;
    c_bank_r <= rd_sel.c_bank;
    d_bank_r <= rd_sel.d_bank;
  end

  always_comb begin
    pa = bank_q[a_bank_r];
    pb = bank_q[b_bank_r];
    pc = bank_q[c_bank_r];
    pd = bank_q[d_bank_r];
    out_pix_nxt.red   = blend(pa.red,   pb.red,   pc.red,   pd.red);
    out_pix_nxt.green = blend(pa.green, pb.green, pc.green, pd.green);
    out_pix_nxt.blue  = blend(pa.blue,  pb.blue,  pc.blue,  pd.blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_r;
    end
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

endmodule

// ===== rtl/bilinear_upscale_2x_unit.sv =====
// pipeline: a read word is registered in the bank read and selection registers, then in the blend
// output register that drives the out_ ports
// throughput: one command word per cycle, writes and reads mixed freely; busy stays low
// the four source neighbors come from four row/column parity banks, one read port each
// a write is visible to a read taken on the very next cycle
// reset (rst_n low, synchronous) clears the pipeline strobes and sets both sizes to 256;
// the frame store is not cleared and has no defined content until written
// ----------------------------------------------------------------------------
// bilinear_upscale_2x_unit
// rgb frame store with a 2x bilinear read-out, one pixel per clock
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_upscale_2x_unit #(
  parameter int MAX_WIDTH  = bu2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bu2_pkg::DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  // command channel
  input  logic       start,
  output logic       busy,
  input  logic       in_command,
  input  logic [8:0] in_row,
  input  logic [8:0] in_col,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  // result channel, one strobe per in-range read word, no back-pressure
  output logic       out_valid,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  // configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  // each parity bank holds every other row and every other column
  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [8:0] width_r, height_r;
  logic       accept;

  logic                  wr_en;
  logic [1:0]            wr_bank;
  logic [AW-1:0]         wr_addr;
  bu2_pkg::pix_t         wr_data;
  logic [3:0][AW-1:0]    rd_addr;
  bu2_pkg::rd_sel_t      rd_sel;
  bu2_pkg::pix_t [3:0]   bank_q;
  bu2_pkg::pix_t         pix_in;
  bu2_pkg::pix_t         out_pix;

  // fully pipelined, a new word every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // size registers, clamped where they are used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bu2_pkg::SIZE_RESET;
      height_r <= bu2_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bu2_pkg::REG_SRC_WIDTH:  width_r  <= cfg_data;
        bu2_pkg::REG_SRC_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pix_in.red   = in_red_in;
  assign pix_in.green = in_green_in;
  assign pix_in.blue  = in_blue_in;

  // address generation: clamp the sizes, mirror or clamp at the borders, map to parity banks
  bu2_agen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_agen (
    .accept     (accept),
    .command    (in_command),
    .row        (in_row),
    .col        (in_col),
    .pix_in     (pix_in),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .wr_en      (wr_en),
    .wr_bank    (wr_bank),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_sel     (rd_sel)
  );

  // four parity banks; bank index is {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    bu2_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_en && (wr_bank == 2'(b))),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr[b]),
      .rd_data (bank_q[b])
    );
  end

  // pick a, b, c, d from the banks and blend them
  bu2_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_sel    (rd_sel),
    .bank_q    (bank_q),
    .out_valid (out_valid),
    .out_pix   (out_pix)
  );

  assign out_red_out   = out_pix.red;
  assign out_green_out = out_pix.green;
  assign out_blue_out  = out_pix.blue;

  // a result word always traces back to an earlier read word
  `BU2_ASSERT_RST(a_out_from_read, clk, rst_n, out_valid |-> $past(accept && (in_command == bu2_pkg::CMD_READ), 2), "result word without a read two cycles earlier")

  // a write word never produces a result
  `BU2_ASSERT_RST(a_write_silent, clk, rst_n, (accept && (in_command == bu2_pkg::CMD_WRITE)) |-> ##2 !out_valid, "write word produced a result")

  // the store is written only for a write word
  `BU2_ASSERT(a_wr_only_on_write, clk, wr_en |-> (accept && (in_command == bu2_pkg::CMD_WRITE)), "bank write without a write word")

endmodule
